### hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define IAN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ian assertion failed");

// Clocked property, checked during reset too.
`define IAN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ian assertion failed");

`endif

### hdl/ian_pkg.sv
package ian_pkg;

   localparam int DEFAULT_NUM_TERMS = 4;
   localparam int COEF_W            = 16;
   localparam int DIV_STEPS         = 49;   // quotient bits of (|dval| << 16) / |scale|

   // register indexes
   localparam logic [2:0] REG_RAW_MIN       = 3'd0;
   localparam logic [2:0] REG_RAW_MAX       = 3'd1;
   localparam logic [2:0] REG_RAW_NEUTRAL   = 3'd2;
   localparam logic [2:0] REG_NATIVE_TYPE   = 3'd3;
   localparam logic [2:0] REG_EMULATED_MODE = 3'd4;
   localparam logic [2:0] REG_MAP_METHOD    = 3'd5;
   localparam logic [2:0] REG_POLY_COEFFS   = 3'd6;
   localparam logic [2:0] REG_POLY_TERMS    = 3'd7;

   localparam logic [1:0] MAP_NONE   = 2'd0;
   localparam logic [1:0] MAP_LINEAR = 2'd1;
   localparam logic [1:0] MAP_POLY   = 2'd2;

   localparam logic AXIS_ABSOLUTE = 1'b0;
   localparam logic AXIS_RELATIVE = 1'b1;

   typedef struct packed {
      logic accept;
      logic ld_diff;
      logic ld_scale;
      logic div_step;
      logic ld_sat;
      logic mul;
      logic add;
      logic ld_out;
   } ian_cmd_type;

   typedef struct packed {
      logic map_on;
      logic poly_on;
      logic scale_zero;
   } ian_status_type;

endpackage

### hdl/ian_datapath.sv
module ian_datapath
   import ian_pkg::*;
#(
   parameter int NUM_TERMS = DEFAULT_NUM_TERMS,
   parameter int TERM_W    = $clog2(NUM_TERMS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data,
   input  logic signed [31:0]   req_raw_value,
   input  ian_cmd_type          cmd,
   input  logic [TERM_W-1:0]    coef_sel,
   output ian_status_type       status,
   output logic [TERM_W-1:0]    n_terms,
   output logic signed [31:0]   rsp_raw_out,
   output logic signed [31:0]   rsp_mapped_value,
   output logic                 rsp_value_valid,
   output logic                 rsp_scale_zero
);

   localparam int CW = NUM_TERMS * COEF_W;

   logic signed [31:0] raw_min_ff, raw_max_ff, raw_neutral_ff;
   logic               native_type_ff, emulated_mode_ff;
   logic [1:0]         map_method_ff;
   logic [CW-1:0]      coef_ff;
   logic [2:0]         poly_terms_ff;
   logic signed [31:0] last_raw_ff, last_raw_in;

   logic signed [31:0] v_ff, v_in;
   logic signed [32:0] dval_ff, dmax_ff, dmin_ff;
   logic [32:0]        den_ff;
   logic [48:0]        num_ff;
   logic [32:0]        rem_ff;
   logic               neg_ff, zero_ff;
   logic signed [31:0] x_ff, acc_ff;
   logic signed [63:0] prod_ff;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_min_ff       <= -32'sd32768;
         raw_max_ff       <= 32'sd32767;
         raw_neutral_ff   <= '0;
         native_type_ff   <= AXIS_ABSOLUTE;
         emulated_mode_ff <= AXIS_ABSOLUTE;
         map_method_ff    <= MAP_NONE;
         coef_ff          <= '0;
         poly_terms_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RAW_MIN:       raw_min_ff       <= csr_data[31:0];
            REG_RAW_MAX:       raw_max_ff       <= csr_data[31:0];
            REG_RAW_NEUTRAL:   raw_neutral_ff   <= csr_data[31:0];
            REG_NATIVE_TYPE:   native_type_ff   <= csr_data[0];
            REG_EMULATED_MODE: emulated_mode_ff <= csr_data[0];
            REG_MAP_METHOD:    map_method_ff    <= csr_data[1:0];
            REG_POLY_COEFFS:   coef_ff          <= csr_data[CW-1:0];
            REG_POLY_TERMS:    poly_terms_ff    <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign n_terms = (32'(poly_terms_ff) > NUM_TERMS) ? TERM_W'(NUM_TERMS)
                                                    : TERM_W'(poly_terms_ff);
   assign status.map_on     = (map_method_ff == MAP_LINEAR) || (map_method_ff == MAP_POLY);
   assign status.poly_on    = (map_method_ff == MAP_POLY);
   assign status.scale_zero = zero_ff;

   // emulation and clamp
   always_comb begin
      logic signed [31:0] t;
      t           = req_raw_value;
      last_raw_in = last_raw_ff;
      if (emulated_mode_ff != native_type_ff) begin
         if (emulated_mode_ff == AXIS_RELATIVE) begin
            t           = req_raw_value - last_raw_ff;
            last_raw_in = req_raw_value;
         end else begin
            t           = req_raw_value + last_raw_ff;
            last_raw_in = t;
         end
      end
      if (native_type_ff == AXIS_ABSOLUTE || emulated_mode_ff == AXIS_ABSOLUTE) begin
         if (t < raw_min_ff) t = raw_min_ff;
         if (t > raw_max_ff) t = raw_max_ff;
      end
      v_in = t;
   end

   always_ff @(posedge clock) begin
      if (reset) last_raw_ff <= '0;
      else if (cmd.accept) last_raw_ff <= last_raw_in;
   end

   // scale selection
   logic signed [32:0] neu33, min33, max33;
   logic [32:0]        mag_max, mag_min, mag_sel, dval_mag;
   logic               sgn_sel;
   assign neu33 = {raw_neutral_ff[31], raw_neutral_ff};
   assign min33 = {raw_min_ff[31], raw_min_ff};
   assign max33 = {raw_max_ff[31], raw_max_ff};
   assign mag_max  = dmax_ff[32] ? 33'(-dmax_ff) : 33'(dmax_ff);
   assign mag_min  = dmin_ff[32] ? 33'(-dmin_ff) : 33'(dmin_ff);
   assign dval_mag = dval_ff[32] ? 33'(-dval_ff) : 33'(dval_ff);

   always_comb begin
      if ((max33 == 33'(-min33)) || (raw_min_ff == raw_neutral_ff)) begin
         mag_sel = mag_max;
         sgn_sel = dmax_ff[32];
      end else if (raw_max_ff == raw_neutral_ff) begin
         mag_sel = mag_min;
         sgn_sel = dmin_ff[32];
      end else begin
         mag_sel = (mag_max > mag_min) ? mag_max : mag_min;
         sgn_sel = 1'b0;
      end
   end

   // restoring divider step
   logic [33:0] trial;
   logic        fits;
   assign trial = {rem_ff, num_ff[48]};
   assign fits  = trial >= {1'b0, den_ff};

   // quotient saturation
   logic signed [31:0] x_sat;
   always_comb begin
      if (neg_ff) x_sat = (num_ff > 49'h0_8000_0000) ? 32'sh8000_0000 : -$signed(num_ff[31:0]);
      else        x_sat = (num_ff > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(num_ff[31:0]);
   end

   // coefficient as Q16.16
   logic [TERM_W-1:0]  idx;
   logic [COEF_W-1:0]  craw;
   logic signed [48:0] cq;
   assign idx  = cmd.ld_sat ? TERM_W'(n_terms - 1'b1) : coef_sel;
   assign craw = coef_ff[idx*COEF_W +: COEF_W];
   assign cq   = {{29{craw[COEF_W-1]}}, craw, 4'b0};

   // Horner add: truncate product toward zero, add, saturate
   logic signed [47:0] tq;
   logic signed [48:0] hs;
   logic signed [31:0] h_sat;
   always_comb begin
      tq = prod_ff[63:16];
      if (prod_ff[63] && (prod_ff[15:0] != '0)) tq = tq + 48'sd1;
      hs = {tq[47], tq} + cq;
      if (hs > 49'sh0_7FFF_FFFF)       h_sat = 32'sh7FFF_FFFF;
      else if (hs < -49'sh0_8000_0000) h_sat = 32'sh8000_0000;
      else                             h_sat = hs[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) v_ff <= v_in;
      if (cmd.ld_diff) begin
         dval_ff <= {v_ff[31], v_ff} - neu33;
         dmax_ff <= max33 - neu33;
         dmin_ff <= min33 - neu33;
      end
      if (cmd.ld_scale) begin
         den_ff  <= mag_sel;
         num_ff  <= {dval_mag, 16'b0};
         rem_ff  <= '0;
         neg_ff  <= dval_ff[32] ^ sgn_sel;
         zero_ff <= (mag_sel == '0);
         acc_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= fits ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         num_ff <= {num_ff[47:0], fits};
      end
      if (cmd.ld_sat) begin
         x_ff <= x_sat;
         if (!status.poly_on)     acc_ff <= x_sat;
         else if (n_terms == '0) acc_ff <= '0;
         else                    acc_ff <= cq[31:0];
      end
      if (cmd.mul) prod_ff <= acc_ff * x_ff;
      if (cmd.add) acc_ff <= h_sat;
      if (cmd.ld_out) begin
         rsp_raw_out      <= v_ff;
         rsp_mapped_value <= acc_ff;
         rsp_value_valid  <= status.map_on;
         rsp_scale_zero   <= status.map_on & zero_ff;
      end
   end

endmodule

### hdl/ian_ctrl.sv
`include "assert_macros.svh"

module ian_ctrl
   import ian_pkg::*;
#(
   parameter int NUM_TERMS = DEFAULT_NUM_TERMS,
   parameter int TERM_W    = $clog2(NUM_TERMS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ian_status_type    status,
   input  logic [TERM_W-1:0] n_terms,
   output ian_cmd_type       cmd,
   output logic [TERM_W-1:0] coef_sel
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIFF  = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_SAT   = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_ADD   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;
   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TERM_W-1:0] k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign coef_sel  = TERM_W'(k_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.ld_diff = 1'b1;
            state_in    = S_SCALE;
         end
         S_SCALE: begin
            cmd.ld_scale = 1'b1;
            state_in     = status.map_on ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (status.scale_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.div_step = 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  cnt_in   = '0;
                  state_in = S_SAT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_SAT: begin
            cmd.ld_sat = 1'b1;
            if (status.poly_on && (n_terms > TERM_W'(1))) begin
               k_in     = TERM_W'(n_terms - 1'b1);
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            k_in     = TERM_W'(k_ff - 1'b1);
            state_in = (k_ff == TERM_W'(1)) ? S_DONE : S_MUL;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.ld_out   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `IAN_ASSERT(a_accept_to_diff, clock, reset, cmd.accept |=> (state_ff == S_DIFF))
   `IAN_ASSERT(a_load_shows, clock, reset, cmd.ld_out |=> rsp_valid_ff)
   `IAN_ASSERT(a_cnt_idle, clock, reset, (state_ff != S_DIV) |-> (cnt_ff == '0))
   `IAN_ASSERT_ALWAYS(a_cmd_onehot, clock, $onehot0(cmd))

endmodule

### hdl/input_axis_normalizer_unit.sv
// Input axis normalizer. Each accepted raw sample word (req_raw_value) is
// optionally turned into the other axis type (relative by differencing with
// the last sample, absolute by accumulating), clamped to [raw_min, raw_max]
// when either side is absolute, and then normalized against the distance
// from raw_neutral to the chosen extreme into signed Q16.16, saturated. The
// result word carries the clamped raw value plus the linear value, a Horner
// polynomial of it (Q4.12 coefficients), or no value. A zero divisor gives
// value 0 with rsp_scale_zero set. One sample is in flight at a time. With
// no mapping the sequencer goes from the difference and scale steps to the
// output word, and a zero divisor skips the divider; with mapping it runs
// the one-bit-per-cycle 49-step divider, saturates the quotient and, for a
// polynomial, does one multiply and one add per further term on the shared
// 32x32 multiplier. The finished word sits in an output register, so a new
// sample is taken while it waits. Registers must be written through
// csr_write_enable/csr_index/csr_data only while the block is idle; the
// block itself does not enforce this.
module input_axis_normalizer_unit
   import ian_pkg::*;
#(
   parameter int NUM_TERMS = DEFAULT_NUM_TERMS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_raw_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_raw_out,
   output logic signed [31:0] rsp_mapped_value,
   output logic               rsp_value_valid,
   output logic               rsp_scale_zero
);

   localparam int TERM_W = $clog2(NUM_TERMS + 1);

   ian_cmd_type       cmd;
   ian_status_type    status;
   logic [TERM_W-1:0] n_terms;
   logic [TERM_W-1:0] coef_sel;

   // sequencer: handshakes, divider count, Horner term count
   ian_ctrl #(.NUM_TERMS(NUM_TERMS), .TERM_W(TERM_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .n_terms   (n_terms),
      .cmd       (cmd),
      .coef_sel  (coef_sel)
   );

   // registers, emulation, divider, multiplier, output word
   ian_datapath #(.NUM_TERMS(NUM_TERMS), .TERM_W(TERM_W)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_raw_value    (req_raw_value),
      .cmd              (cmd),
      .coef_sel         (coef_sel),
      .status           (status),
      .n_terms          (n_terms),
      .rsp_raw_out      (rsp_raw_out),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_value_valid  (rsp_value_valid),
      .rsp_scale_zero   (rsp_scale_zero)
   );

endmodule

### sim/tb_input_axis_normalizer_unit.sv
module tb_input_axis_normalizer_unit;
   import ian_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  N_TERMS     = DEFAULT_NUM_TERMS;
   localparam int  DRAIN_WAIT  = 80;     // longest mapped latency plus margin
   localparam longint LIMIT    = 1000000;

   typedef struct packed {
      logic signed [31:0] raw_out;
      logic signed [31:0] mapped_value;
      logic               value_valid;
      logic               scale_zero;
   } axis_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_raw_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_raw_out;
   logic signed [31:0] rsp_mapped_value;
   logic               rsp_value_valid;
   logic               rsp_scale_zero;

   input_axis_normalizer_unit dut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the configuration and history.
   // ---------------------------------------------------------------
   longint    cfg_min, cfg_max, cfg_neutral;
   logic      cfg_native, cfg_emulated;
   logic [1:0] cfg_map;
   logic [63:0] cfg_coeffs;
   logic [2:0] cfg_terms;
   longint    prev_sample;

   logic signed [31:0] sample_queue[$];   // words waiting for the driver
   axis_result_type    expected_words[$]; // predictions waiting for the monitor
   int                 mismatches = 0;
   longint             cycle_count = 0;
   bit                 hold_rsp = 0;      // long receiver hold-off request
   bit                 gap_ok = 1;        // random idling enabled

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint coeff_as_q16(int k);
      logic signed [15:0] c;
      c = cfg_coeffs[16*k +: 16];
      return longint'(c) * 16;
   endfunction

   function automatic longint horner(longint x);
      int n;
      longint acc;
      n = (cfg_terms > N_TERMS) ? N_TERMS : cfg_terms;
      if (n == 0) return 0;
      acc = coeff_as_q16(n - 1);
      for (int k = n - 1; k > 0; k--) begin
         acc = (acc * x) / 65536;
         acc = clip32(acc + coeff_as_q16(k - 1));
      end
      return acc;
   endfunction

   // Updates the history and returns the normalized word for one sample.
   function automatic axis_result_type normalize_sample(logic signed [31:0] sample);
      axis_result_type r;
      longint v, dmax, dmin, dval, scale, x;
      logic [31:0] wrapped;
      v = sample;
      r = '0;
      if (cfg_emulated != cfg_native) begin
         if (cfg_emulated == AXIS_RELATIVE) begin
            wrapped = sample - 32'(prev_sample);
            v = longint'(signed'(wrapped));
            prev_sample = sample;
         end else begin
            wrapped = sample + 32'(prev_sample);
            v = longint'(signed'(wrapped));
            prev_sample = v;
         end
      end
      if (cfg_native == AXIS_ABSOLUTE || cfg_emulated == AXIS_ABSOLUTE) begin
         if (v < cfg_min) v = cfg_min;
         if (v > cfg_max) v = cfg_max;
      end
      r.raw_out = 32'(v);
      if (cfg_map == MAP_LINEAR || cfg_map == MAP_POLY) begin
         dmax = cfg_max - cfg_neutral;
         dmin = cfg_min - cfg_neutral;
         dval = v - cfg_neutral;
         r.value_valid = 1'b1;
         if (cfg_max == -cfg_min || cfg_min == cfg_neutral) scale = dmax;
         else if (cfg_max == cfg_neutral) scale = dmin;
         else begin
            if (dmax < 0) dmax = -dmax;
            if (dmin < 0) dmin = -dmin;
            scale = (dmax > dmin) ? dmax : dmin;
         end
         if (scale == 0) r.scale_zero = 1'b1;
         else begin
            x = clip32((dval * 65536) / scale);
            r.mapped_value = 32'((cfg_map == MAP_LINEAR) ? x : horner(x));
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers queued words, random gaps between them.
   // ---------------------------------------------------------------
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_words.push_back(normalize_sample(req_raw_value));
            void'(sample_queue.pop_front());
            send_gap <= gap_ok ? pick_gap() : 0;
         end
         if (req_valid && req_stall) begin
            // hold word steady while stalled
         end else if (sample_queue.size() != 0 && send_gap == 0 &&
                      !(req_valid && !req_stall && sample_queue.size() == 0)) begin
            req_valid     <= 1'b1;
            req_raw_value <= sample_queue[0];
         end else begin
            req_valid <= 1'b0;
            if (send_gap > 0 && !(req_valid && !req_stall)) send_gap <= send_gap - 1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random stall, plus a long hold-off on request.
   // ---------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      axis_result_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_raw_out, rsp_mapped_value, rsp_value_valid, rsp_scale_zero};
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word raw=%0d val=%0d",
                                              rsp_raw_out, rsp_mapped_value);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp raw=%0d val=%0d vv=%b sz=%b",
                               " got raw=%0d val=%0d vv=%b sz=%b"},
                              want.raw_out, want.mapped_value, want.value_valid,
                              want.scale_zero, got.raw_out, got.mapped_value,
                              got.value_valid, got.scale_zero);
               end
            end
         end
         if (hold_rsp) rsp_stall <= 1'b1;
         else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (gap_ok && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
            rsp_stall  <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_RAW_MIN:       cfg_min      = longint'(signed'(val[31:0]));
         REG_RAW_MAX:       cfg_max      = longint'(signed'(val[31:0]));
         REG_RAW_NEUTRAL:   cfg_neutral  = longint'(signed'(val[31:0]));
         REG_NATIVE_TYPE:   cfg_native   = val[0];
         REG_EMULATED_MODE: cfg_emulated = val[0];
         REG_MAP_METHOD:    cfg_map      = val[1:0];
         REG_POLY_COEFFS:   cfg_coeffs   = val;
         REG_POLY_TERMS:    cfg_terms    = val[2:0];
         default: ;
      endcase
   endtask

   // Waits until every queued word is sent and answered, then settles.
   task automatic drain();
      while (sample_queue.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic setup(longint mn, longint mx, longint nt, logic nat, logic emu,
                        logic [1:0] mm, logic [63:0] co, logic [2:0] nterm);
      drain();
      write_reg(REG_RAW_MIN, 64'(mn));
      write_reg(REG_RAW_MAX, 64'(mx));
      write_reg(REG_RAW_NEUTRAL, 64'(nt));
      write_reg(REG_NATIVE_TYPE, 64'(nat));
      write_reg(REG_EMULATED_MODE, 64'(emu));
      write_reg(REG_MAP_METHOD, 64'(mm));
      write_reg(REG_POLY_COEFFS, co);
      write_reg(REG_POLY_TERMS, 64'(nterm));
   endtask

   function automatic logic signed [31:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2: return 32'(longint'(cfg_min) + $urandom_range(0, 3) - 1);
         3: return 32'(longint'(cfg_max) + $urandom_range(0, 3) - 1);
         default: return 32'(longint'(cfg_neutral) + $signed($urandom_range(0, 80000)) - 40000);
      endcase
   endfunction

   initial begin
      cfg_min = -32768; cfg_max = 32767; cfg_neutral = 0;
      cfg_native = AXIS_ABSOLUTE; cfg_emulated = AXIS_ABSOLUTE;
      cfg_map = MAP_NONE; cfg_coeffs = '0; cfg_terms = '0; prev_sample = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: no value, clamp to 16-bit range.
      sample_queue = '{32'sh7fffffff, 32'sh80000000, 0, -5, 40000};
      // Symmetric ranges, linear and polynomial mapping, three emulation combinations.
      setup(-32768, 32767, 0, AXIS_ABSOLUTE, AXIS_ABSOLUTE, MAP_LINEAR, 0, 0);
      sample_queue = '{32767, -32768, 0, 100, 32'sh80000000};
      setup(-1000, 1000, 0, AXIS_ABSOLUTE, AXIS_RELATIVE, MAP_LINEAR, 0, 0);
      sample_queue = '{500, 32'sh80000000, 32'sh7fffffff, 12};    // wrapping differences
      setup(-2147483648, 2147483647, 0, AXIS_RELATIVE, AXIS_ABSOLUTE, MAP_POLY,
            64'h1000_f800_0400_0100, 4);
      sample_queue = '{32'sh7fffffff, 32'sh7fffffff, -3};         // wrapping running sum
      // Inverted range, zero divisor, unused method, too many terms.
      setup(100, -100, 0, AXIS_ABSOLUTE, AXIS_ABSOLUTE, MAP_LINEAR, 0, 0);
      sample_queue = '{5, -500};
      setup(7, 7, 7, AXIS_RELATIVE, AXIS_RELATIVE, MAP_POLY, 64'hffff_ffff_ffff_ffff, 7);
      sample_queue = '{9, -9};
      setup(0, 0, 0, AXIS_ABSOLUTE, AXIS_ABSOLUTE, 2'd3, 0, 0);
      sample_queue = '{1};
      setup(-10, 50, 30, AXIS_RELATIVE, AXIS_RELATIVE, MAP_POLY, 64'h7fff_8000_7fff_8000, 0);
      sample_queue = '{32'sh80000000, 44};

      // Random phases over random configurations.
      for (int ph = 0; ph < 25; ph++) begin
         longint a, b;
         a = longint'(signed'($urandom));
         b = longint'(signed'($urandom));
         if ($urandom_range(0, 2) == 0) begin
            a = -longint'($urandom_range(1, 70000));
            b = -a;
         end
         else if ($urandom_range(0, 1)) begin a = a >>> 12; b = b >>> 12; end
         if (a > b && $urandom_range(0, 4) != 0) begin longint t; t = a; a = b; b = t; end
         setup(a, b, ($urandom_range(0, 3) == 0) ? a :
                     ($urandom_range(0, 3) == 0) ? b : (a + b) / 2,
               $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3),
               {$urandom, $urandom}, $urandom_range(0, 7));
         if (ph == 10) begin
            // Receiver holds off while the sender keeps offering words.
            hold_rsp = 1;
            repeat (50) sample_queue.push_back(rand_sample());
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else
            repeat (50) sample_queue.push_back(rand_sample());
         gap_ok = (ph % 6 != 3);   // some stretches without idling
      end

      drain();
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

### input_axis_normalizer_unit.f
+incdir+hdl
hdl/ian_pkg.sv
hdl/ian_datapath.sv
hdl/ian_ctrl.sv
hdl/input_axis_normalizer_unit.sv
sim/tb_input_axis_normalizer_unit.sv
